/* rtl/zmp_preview_controller_core_macros.svh */
// Assertion macros shared by the ZMP preview controller RTL.
`ifndef ZMP_PREVIEW_CONTROLLER_CORE_MACROS_SVH
`define ZMP_PREVIEW_CONTROLLER_CORE_MACROS_SVH

// Invariant checked at every rising clock edge outside reset.
`define ZMP_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define ZMP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ZMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/zmp_pkg.sv */
// Types and constants shared by the ZMP preview controller modules.
`timescale 1ns / 1ps
package zmp_pkg;

  // Accumulator width: covers the widest state-update sum with margin
  localparam int unsigned ACC_W = 112;
  // Entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Input opcode values
  localparam logic OPC_GAIN = 1'b0;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STEP_DT   = 3'd0,
    REG_HALF_DT2  = 3'd1,
    REG_SIXTH_DT3 = 3'd2,
    REG_ZMP_RATIO = 3'd3,
    REG_FB_POS    = 3'd4,
    REG_FB_VEL    = 3'd5,
    REG_FB_ACC    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [39:0]        step_dt;
    logic [39:0]        half_dt2;
    logic [39:0]        sixth_dt3;
    logic [39:0]        zmp_ratio;
    logic signed [39:0] fb_pos;
    logic signed [39:0] fb_vel;
    logic signed [39:0] fb_acc;
  } cfg_t;

  typedef enum logic {
    KIND_GAIN,
    KIND_SAMPLE
  } item_kind_e;

  // One classified transaction held in the queue
  typedef struct packed {
    item_kind_e         kind;
    logic [6:0]         gain_index;
    logic signed [39:0] gain_value;
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_push_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREVIEW,
    ST_FB,
    ST_U_WAIT,
    ST_ZMP,
    ST_ZMP_WAIT,
    ST_N0,
    ST_N0_WAIT,
    ST_N1,
    ST_N1_WAIT,
    ST_N2,
    ST_N2_WAIT,
    ST_OUT
  } back_state_e;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    A_GAIN,
    A_KP,
    A_KV,
    A_KA,
    A_RATIO,
    A_DT,
    A_H,
    A_S6
  } a_sel_e;

  typedef enum logic [2:0] {
    B_WIN,
    B_ST0,
    B_ST1,
    B_ST2,
    B_U
  } b_sel_e;

  // One partial-product operation
  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    logic   hi;     // upper chunk of the wide operand, weight 2^32
    logic   pre16;  // preview product, weight 2^16
    logic   neg;    // subtract from the accumulator
  } op_desc_t;

endpackage

/* rtl/zmp_preview_controller_core.sv */
// Top level of the two-axis cart-table ZMP preview controller.
// A gain transaction or a sample that only fills the window is consumed by the
// back end without a control step. Once the window holds PREVIEW_STEPS samples,
// each sample runs one control step: one gain-table and window read per cycle
// feeds a two-lane MAC for the preview sum, followed by a short sequence of
// split 41x33 partial products for feedback, ZMP estimate and state update.
// A two-entry queue lets the input side keep accepting while a step runs, and
// the result register holds a finished result until it is taken.
`timescale 1ns / 1ps
module zmp_preview_controller_core
  import zmp_pkg::*;
#(
  parameter int unsigned PREVIEW_STEPS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [39:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [6:0]         gain_index_i,
  input  logic signed [39:0] gain_value_i,
  input  logic signed [31:0] ref_x_i,
  input  logic signed [31:0] ref_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] com_x_pos_o,
  output logic signed [31:0] com_y_pos_o,
  output logic signed [31:0] com_x_vel_o,
  output logic signed [31:0] com_y_vel_o,
  output logic signed [31:0] zmp_x_est_o,
  output logic signed [31:0] zmp_y_est_o
);

  cfg_t    cfg_q;
  q_push_t push;
  q_head_t head;
  logic    q_full, q_pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_dt   <= 40'd10995116278;
      cfg_q.half_dt2  <= 40'd54975581;
      cfg_q.sixth_dt3 <= 40'd183251;
      cfg_q.zmp_ratio <= '0;
      cfg_q.fb_pos    <= '0;
      cfg_q.fb_vel    <= '0;
      cfg_q.fb_acc    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_DT:   cfg_q.step_dt   <= cfg_data_i;
        REG_HALF_DT2:  cfg_q.half_dt2  <= cfg_data_i;
        REG_SIXTH_DT3: cfg_q.sixth_dt3 <= cfg_data_i;
        REG_ZMP_RATIO: cfg_q.zmp_ratio <= cfg_data_i;
        REG_FB_POS:    cfg_q.fb_pos    <= $signed(cfg_data_i);
        REG_FB_VEL:    cfg_q.fb_vel    <= $signed(cfg_data_i);
        REG_FB_ACC:    cfg_q.fb_acc    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  zmp_front #(
    .PREVIEW_STEPS(PREVIEW_STEPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .gain_index_i(gain_index_i),
    .gain_value_i(gain_value_i),
    .ref_x_i     (ref_x_i),
    .ref_y_i     (ref_y_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  zmp_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .pop_i (q_pop),
    .full_o(q_full),
    .head_o(head)
  );

  zmp_back #(
    .PREVIEW_STEPS(PREVIEW_STEPS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_head_i   (head),
    .q_pop_o    (q_pop),
    .cfg_i      (cfg_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .com_x_pos_o(com_x_pos_o),
    .com_y_pos_o(com_y_pos_o),
    .com_x_vel_o(com_x_vel_o),
    .com_y_vel_o(com_y_vel_o),
    .zmp_x_est_o(zmp_x_est_o),
    .zmp_y_est_o(zmp_y_est_o)
  );

endmodule

/* rtl/zmp_front.sv */
// Front end: accepts input transactions, classifies them and feeds the queue.
`timescale 1ns / 1ps
module zmp_front
  import zmp_pkg::*;
#(
  parameter int unsigned PREVIEW_STEPS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [6:0]         gain_index_i,
  input  logic signed [39:0] gain_value_i,
  input  logic signed [31:0] ref_x_i,
  input  logic signed [31:0] ref_y_i,
  input  logic               q_full_i,
  output q_push_t            push_o
);

  logic in_range;
  logic accept;

  // Gains aimed past the end of the table are accepted and dropped
  assign in_range   = 11'(gain_index_i) < 11'(PREVIEW_STEPS);
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    push_o.item.kind       = (opcode_i == OPC_GAIN) ? KIND_GAIN : KIND_SAMPLE;
    push_o.item.gain_index = gain_index_i;
    push_o.item.gain_value = gain_value_i;
    push_o.item.ref_x      = ref_x_i;
    push_o.item.ref_y      = ref_y_i;
    push_o.valid           = accept && ((opcode_i != OPC_GAIN) || in_range);
  end

endmodule

/* rtl/zmp_queue.sv */
// Short queue of classified transactions between front and back.
`timescale 1ns / 1ps
module zmp_queue
  import zmp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  input  logic    pop_i,
  output logic    full_o,
  output q_head_t head_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  q_item_t        mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]  cnt_q;
  logic           do_push, do_pop;

  assign full_o      = cnt_q == CW'(QUEUE_DEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.item  = mem_q[rptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  // Pointer and count update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.item;
    end
  end

endmodule

/* rtl/zmp_back.sv */
// Back end: preview window, gain table and the two-lane MAC sequencer.
`timescale 1ns / 1ps
`include "zmp_preview_controller_core_macros.svh"
module zmp_back
  import zmp_pkg::*;
#(
  parameter int unsigned PREVIEW_STEPS = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  q_head_t            q_head_i,
  output logic               q_pop_o,
  input  cfg_t               cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] com_x_pos_o,
  output logic signed [31:0] com_y_pos_o,
  output logic signed [31:0] com_x_vel_o,
  output logic signed [31:0] com_y_vel_o,
  output logic signed [31:0] zmp_x_est_o,
  output logic signed [31:0] zmp_y_est_o
);

  localparam int unsigned AW  = (PREVIEW_STEPS > 1) ? $clog2(PREVIEW_STEPS) : 1;
  localparam int unsigned FW  = $clog2(PREVIEW_STEPS + 1);
  localparam int unsigned IXW = (AW > 7) ? AW : 7;

  // Round half up at bit sh, then saturate to w signed bits (sign-extended to 64)
  function automatic logic signed [63:0] rnd_sat(logic signed [ACC_W-1:0] v,
                                                  int unsigned sh, int unsigned w);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] upper;
    logic signed [63:0]      maxv;
    r     = $signed(v + (ACC_W'(1) << (sh - 1))) >>> sh;
    upper = r >>> (w - 1);
    maxv  = 64'sh7FFF_FFFF_FFFF_FFFF >>> (64 - w);
    if ((upper == '0) || (&upper)) begin
      return r[63:0];
    end
    return r[ACC_W-1] ? ~maxv : maxv;
  endfunction

  back_state_e state_q, state_d;

  logic [2:0]    sub_q;
  logic [AW-1:0] i_q, ridx_q, head_q, head_next;
  logic [FW-1:0] fill_q, fill_next;
  logic          fill_full;
  logic          v1_q, v2_q, drained;
  logic          issue, last, load_out, out_valid_q;
  op_desc_t      desc, d1_q, d2_q;

  // Memories
  logic signed [39:0] gain_mem [PREVIEW_STEPS];
  logic signed [31:0] winx_mem [PREVIEW_STEPS];
  logic signed [31:0] winy_mem [PREVIEW_STEPS];
  logic signed [39:0] gain_rd_q;
  logic signed [31:0] win_rd_q [2];
  logic [IXW-1:0]     gidx_ext;
  logic [AW-1:0]      gaddr;

  // Datapath
  logic signed [47:0]      st_q  [2][3];
  logic signed [47:0]      n_q   [2][3];
  logic signed [63:0]      u_q   [2];
  logic signed [31:0]      zmp_q [2];
  logic signed [40:0]      a_op;
  logic signed [32:0]      b_op  [2];
  logic signed [73:0]      prod_d [2];
  logic signed [73:0]      prod_q [2];
  logic signed [ACC_W-1:0] term  [2];
  logic signed [ACC_W-1:0] acc_q [2];
  logic signed [31:0]      pos_d [2];
  logic signed [31:0]      vel_d [2];
  logic signed [31:0]      pos_q [2];
  logic signed [31:0]      vel_q [2];
  logic signed [31:0]      zout_q [2];

  assign head_next = (head_q == AW'(PREVIEW_STEPS - 1)) ? '0 : head_q + 1'b1;
  assign fill_next = (fill_q == FW'(PREVIEW_STEPS)) ? fill_q : fill_q + 1'b1;
  assign fill_full = fill_next == FW'(PREVIEW_STEPS);
  assign drained   = !v1_q && !v2_q;
  assign gidx_ext  = IXW'(q_head_i.item.gain_index);
  assign gaddr     = gidx_ext[AW-1:0];
  assign load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_head_i.valid && q_head_i.item.kind == KIND_SAMPLE && fill_full) begin
          state_d = ST_PREVIEW;
        end
      end
      ST_PREVIEW:  if (i_q == AW'(PREVIEW_STEPS - 1)) state_d = ST_FB;
      ST_FB:       if (last) state_d = ST_U_WAIT;
      ST_U_WAIT:   if (drained) state_d = ST_ZMP;
      ST_ZMP:      if (last) state_d = ST_ZMP_WAIT;
      ST_ZMP_WAIT: if (drained) state_d = ST_N0;
      ST_N0:       if (last) state_d = ST_N0_WAIT;
      ST_N0_WAIT:  if (drained) state_d = ST_N1;
      ST_N1:       if (last) state_d = ST_N1_WAIT;
      ST_N1_WAIT:  if (drained) state_d = ST_N2;
      ST_N2:       if (last) state_d = ST_N2_WAIT;
      ST_N2_WAIT:  if (drained) state_d = ST_OUT;
      ST_OUT:      if (load_out) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: operation descriptor per issue cycle
  always_comb begin
    q_pop_o    = 1'b0;
    issue      = 1'b0;
    last       = 1'b0;
    desc.a_sel = A_GAIN;
    desc.b_sel = B_WIN;
    desc.hi    = sub_q[0];
    desc.pre16 = 1'b0;
    desc.neg   = 1'b0;
    unique case (state_q)
      ST_IDLE: q_pop_o = q_head_i.valid;
      ST_PREVIEW: begin
        issue      = 1'b1;
        desc.hi    = 1'b0;
        desc.pre16 = 1'b1;
      end
      ST_FB: begin
        issue    = 1'b1;
        last     = sub_q == 3'd5;
        desc.neg = 1'b1;
        case (sub_q[2:1])
          2'd0:    begin desc.a_sel = A_KP; desc.b_sel = B_ST0; end
          2'd1:    begin desc.a_sel = A_KV; desc.b_sel = B_ST1; end
          default: begin desc.a_sel = A_KA; desc.b_sel = B_ST2; end
        endcase
      end
      ST_ZMP: begin
        issue      = 1'b1;
        last       = sub_q == 3'd1;
        desc.neg   = 1'b1;
        desc.a_sel = A_RATIO;
        desc.b_sel = B_ST2;
      end
      ST_N0: begin
        issue = 1'b1;
        last  = sub_q == 3'd5;
        case (sub_q[2:1])
          2'd0:    begin desc.a_sel = A_DT; desc.b_sel = B_ST1; end
          2'd1:    begin desc.a_sel = A_H;  desc.b_sel = B_ST2; end
          default: begin desc.a_sel = A_S6; desc.b_sel = B_U;   end
        endcase
      end
      ST_N1: begin
        issue = 1'b1;
        last  = sub_q == 3'd3;
        case (sub_q[2:1])
          2'd0:    begin desc.a_sel = A_DT; desc.b_sel = B_ST2; end
          default: begin desc.a_sel = A_H;  desc.b_sel = B_U;   end
        endcase
      end
      ST_N2: begin
        issue      = 1'b1;
        last       = sub_q == 3'd1;
        desc.a_sel = A_DT;
        desc.b_sel = B_U;
      end
      default: ;
    endcase
  end

  // Operand select and multiply (both lanes share the coefficient operand)
  always_comb begin
    unique case (d1_q.a_sel)
      A_GAIN:  a_op = 41'(gain_rd_q);
      A_KP:    a_op = 41'($signed(cfg_i.fb_pos));
      A_KV:    a_op = 41'($signed(cfg_i.fb_vel));
      A_KA:    a_op = 41'($signed(cfg_i.fb_acc));
      A_RATIO: a_op = $signed({1'b0, cfg_i.zmp_ratio});
      A_DT:    a_op = $signed({1'b0, cfg_i.step_dt});
      A_H:     a_op = $signed({1'b0, cfg_i.half_dt2});
      A_S6:    a_op = $signed({1'b0, cfg_i.sixth_dt3});
      default: a_op = '0;
    endcase
    for (int l = 0; l < 2; l++) begin
      unique case (d1_q.b_sel)
        B_WIN: b_op[l] = 33'(win_rd_q[l]);
        B_ST0: b_op[l] = d1_q.hi ? 33'($signed(st_q[l][0][47:32]))
                                 : $signed({1'b0, st_q[l][0][31:0]});
        B_ST1: b_op[l] = d1_q.hi ? 33'($signed(st_q[l][1][47:32]))
                                 : $signed({1'b0, st_q[l][1][31:0]});
        B_ST2: b_op[l] = d1_q.hi ? 33'($signed(st_q[l][2][47:32]))
                                 : $signed({1'b0, st_q[l][2][31:0]});
        B_U:   b_op[l] = d1_q.hi ? 33'($signed(u_q[l][63:32]))
                                 : $signed({1'b0, u_q[l][31:0]});
        default: b_op[l] = '0;
      endcase
      prod_d[l] = a_op * b_op[l];
    end
  end

  // Align registered products to the accumulator weight
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      term[l] = ACC_W'(prod_q[l]);
      if (d2_q.pre16) begin
        term[l] = term[l] <<< 16;
      end else if (d2_q.hi) begin
        term[l] = term[l] <<< 32;
      end
      pos_d[l] = 32'(rnd_sat(ACC_W'(n_q[l][0]), 16, 32));
      vel_d[l] = 32'(rnd_sat(ACC_W'(n_q[l][1]), 16, 32));
    end
  end

  // Control registers and cart state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sub_q       <= '0;
      i_q         <= '0;
      ridx_q      <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < 2; l++) begin
        for (int k = 0; k < 3; k++) begin
          st_q[l][k] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (q_pop_o && q_head_i.item.kind == KIND_SAMPLE) begin
        head_q <= head_next;
        fill_q <= fill_next;
        i_q    <= '0;
        ridx_q <= head_next;
        sub_q  <= '0;
      end
      if (state_q == ST_PREVIEW) begin
        i_q    <= i_q + 1'b1;
        ridx_q <= (ridx_q == AW'(PREVIEW_STEPS - 1)) ? '0 : ridx_q + 1'b1;
      end else if (issue) begin
        sub_q <= last ? 3'd0 : sub_q + 3'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        for (int l = 0; l < 2; l++) begin
          for (int k = 0; k < 3; k++) begin
            st_q[l][k] <= n_q[l][k];
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Memory writes and registered reads
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_head_i.item.kind == KIND_GAIN) begin
      gain_mem[gaddr] <= q_head_i.item.gain_value;
    end
    if (q_pop_o && q_head_i.item.kind == KIND_SAMPLE) begin
      winx_mem[head_q] <= q_head_i.item.ref_x;
      winy_mem[head_q] <= q_head_i.item.ref_y;
    end
    gain_rd_q   <= gain_mem[i_q];
    win_rd_q[0] <= winx_mem[ridx_q];
    win_rd_q[1] <= winy_mem[ridx_q];
  end

  // MAC pipeline, phase results and output payload
  always_ff @(posedge clk_i) begin
    d1_q <= desc;
    d2_q <= d1_q;
    for (int l = 0; l < 2; l++) begin
      prod_q[l] <= prod_d[l];
      if (v2_q) begin
        acc_q[l] <= d2_q.neg ? acc_q[l] - term[l] : acc_q[l] + term[l];
      end else if (q_pop_o && q_head_i.item.kind == KIND_SAMPLE) begin
        acc_q[l] <= '0;
      end else if (drained) begin
        case (state_q)
          ST_U_WAIT: begin
            u_q[l]   <= rnd_sat(acc_q[l], 16, 64);
            acc_q[l] <= ACC_W'(st_q[l][0]) <<< 40;
          end
          ST_ZMP_WAIT: begin
            zmp_q[l] <= 32'(rnd_sat(acc_q[l], 56, 32));
            acc_q[l] <= ACC_W'(st_q[l][0]) <<< 40;
          end
          ST_N0_WAIT: begin
            n_q[l][0] <= 48'(rnd_sat(acc_q[l], 40, 48));
            acc_q[l]  <= ACC_W'(st_q[l][1]) <<< 40;
          end
          ST_N1_WAIT: begin
            n_q[l][1] <= 48'(rnd_sat(acc_q[l], 40, 48));
            acc_q[l]  <= ACC_W'(st_q[l][2]) <<< 40;
          end
          ST_N2_WAIT: n_q[l][2] <= 48'(rnd_sat(acc_q[l], 40, 48));
          default: ;
        endcase
      end
      if (load_out) begin
        pos_q[l]  <= pos_d[l];
        vel_q[l]  <= vel_d[l];
        zout_q[l] <= zmp_q[l];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign com_x_pos_o = pos_q[0];
  assign com_y_pos_o = pos_q[1];
  assign com_x_vel_o = vel_q[0];
  assign com_y_vel_o = vel_q[1];
  assign zmp_x_est_o = zout_q[0];
  assign zmp_y_est_o = zout_q[1];

  // Checks
  `ZMP_ASSERT_IMPL(a_idle_drained, state_q == ST_IDLE, !v1_q && !v2_q, "MAC busy in idle")
  `ZMP_ASSERT(a_fill_range, fill_q <= FW'(PREVIEW_STEPS), "window fill past depth")
  `ZMP_ASSERT_IMPL(a_step_full, state_q == ST_PREVIEW, fill_q == FW'(PREVIEW_STEPS),
                   "step on partial window")
  `ZMP_ASSERT_NEXT(a_out_load, load_out, out_valid_q && state_q == ST_IDLE, "result not posted")

endmodule

/* tb/zmp_preview_controller_core_tb.sv */
// Self-checking testbench for the two-axis ZMP preview controller core.
`timescale 1ns / 1ps
module zmp_preview_controller_core_tb;
  import zmp_pkg::*;

  localparam int unsigned NSTEPS     = 128;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_WAIT = 400;
  localparam logic        OPC_SAMPLE = 1'b1;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] zx;
    logic [31:0] zy;
  } com_result_t;

  typedef struct {
    logic               opcode;
    logic [6:0]         gidx;
    logic signed [39:0] gval;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    bit                 typed;
    com_result_t        want;
  } stim_row_t;

  logic               clk_i, rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [39:0]        cfg_data_i;
  logic               in_valid_i, in_ready_o;
  logic               opcode_i;
  logic [6:0]         gain_index_i;
  logic signed [39:0] gain_value_i;
  logic signed [31:0] ref_x_i, ref_y_i;
  logic               out_valid_o, out_ready_i;
  logic signed [31:0] com_x_pos_o, com_y_pos_o, com_x_vel_o, com_y_vel_o;
  logic signed [31:0] zmp_x_est_o, zmp_y_est_o;

  zmp_preview_controller_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .gain_index_i, .gain_value_i,
    .ref_x_i, .ref_y_i, .out_valid_o, .out_ready_i,
    .com_x_pos_o, .com_y_pos_o, .com_x_vel_o, .com_y_vel_o,
    .zmp_x_est_o, .zmp_y_est_o
  );

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // predictor state
  logic signed [127:0] k_dt, k_h, k_s6, k_ratio, k_fp, k_fv, k_fa;
  logic signed [127:0] cart_st [2][3];
  logic signed [31:0]  ref_win [2][NSTEPS];
  logic signed [39:0]  gain_tab [NSTEPS];
  int unsigned         win_head, win_fill;
  com_result_t         pending_q [$];

  int unsigned errors, items_sent, results_seen, gain_loads, idle_cnt;
  int unsigned send_idle_pct, recv_stall_pct;

  // round half up, floor shift, saturate to a signed width
  function automatic logic signed [127:0] round_sat(input logic signed [127:0] a,
                                                     input int s, input int bits);
    logic signed [127:0] r, mx;
    r  = (a + (128'sd1 <<< (s - 1))) >>> s;
    mx = (128'sd1 <<< (bits - 1)) - 128'sd1;
    if (r > mx) r = mx;
    else if (r < -mx - 128'sd1) r = -mx - 128'sd1;
    return r;
  endfunction

  // one control step of one axis
  task automatic step_axis(input int ax, output logic [31:0] pos, vel, zmp);
    logic signed [127:0] acc, u, n0, n1, n2, s0, s1, s2;
    int unsigned idx;
    acc = '0;
    idx = win_head;
    for (int i = 0; i < NSTEPS; i++) begin
      acc = acc + gain_tab[i] * ref_win[ax][idx];
      idx = (idx + 1 >= NSTEPS) ? 0 : idx + 1;
    end
    s0  = cart_st[ax][0];
    s1  = cart_st[ax][1];
    s2  = cart_st[ax][2];
    acc = (acc <<< 16) - (k_fp * s0 + k_fv * s1 + k_fa * s2);
    u   = round_sat(acc, 16, 64);
    zmp = 32'(round_sat((s0 <<< 40) - k_ratio * s2, 56, 32));
    n0  = round_sat((s0 <<< 40) + k_dt * s1 + k_h * s2 + k_s6 * u, 40, 48);
    n1  = round_sat((s1 <<< 40) + k_dt * s2 + k_h * u, 40, 48);
    n2  = round_sat((s2 <<< 40) + k_dt * u, 40, 48);
    cart_st[ax][0] = n0;
    cart_st[ax][1] = n1;
    cart_st[ax][2] = n2;
    pos = 32'(round_sat(n0, 16, 32));
    vel = 32'(round_sat(n1, 16, 32));
  endtask

  // update the model for one accepted transaction; returns 1 on a result
  task automatic predict_item(input stim_row_t r, output bit produced,
                              output com_result_t res);
    produced = 1'b0;
    res      = '0;
    if (r.opcode == OPC_GAIN) begin
      if (r.gidx < NSTEPS) gain_tab[r.gidx] = r.gval;
      gain_loads++;
    end else begin
      ref_win[0][win_head] = r.rx;
      ref_win[1][win_head] = r.ry;
      win_head = (win_head + 1 >= NSTEPS) ? 0 : win_head + 1;
      if (win_fill < NSTEPS) win_fill++;
      if (win_fill == NSTEPS) begin
        step_axis(0, res.px, res.vx, res.zx);
        step_axis(1, res.py, res.vy, res.zy);
        produced = 1'b1;
      end
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // drive one transaction and wait for acceptance
  task automatic send_item(input stim_row_t r);
    bit produced;
    com_result_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    opcode_i     = r.opcode;
    gain_index_i = r.gidx;
    gain_value_i = r.gval;
    ref_x_i      = r.rx;
    ref_y_i      = r.ry;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_item(r, produced, res);
    if (produced) pending_q.push_back(r.typed ? r.want : res);
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [39:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    case (idx)
      REG_STEP_DT:   k_dt    = val;
      REG_HALF_DT2:  k_h     = val;
      REG_SIXTH_DT3: k_s6    = val;
      REG_ZMP_RATIO: k_ratio = val;
      REG_FB_POS:    k_fp    = $signed(val);
      REG_FB_VEL:    k_fv    = $signed(val);
      REG_FB_ACC:    k_fa    = $signed(val);
      default: ;
    endcase
  endtask

  // hold the sender until every expected result is back, then let the core settle
  task automatic drain();
    end_burst();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [39:0] rand40();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [31:0] rand_ref();
    if ($urandom_range(3) == 0) return $urandom;
    return $signed($urandom_range(1 << 18)) - (1 << 17);
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t r;
    r.opcode = ($urandom_range(99) < 15) ? OPC_GAIN : OPC_SAMPLE;
    r.gidx   = 7'($urandom);
    r.gval   = ($urandom_range(3) == 0) ? rand40()
               : $signed(40'($urandom_range(1 << 20))) - (1 << 19);
    r.rx     = rand_ref();
    r.ry     = rand_ref();
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic op, input logic [6:0] gi,
                                       input logic [39:0] gv, input logic [31:0] x, y);
    stim_row_t r;
    r.opcode = op;
    r.gidx   = gi;
    r.gval   = gv;
    r.rx     = x;
    r.ry     = y;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  // output side: stall control at the falling edge
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // result checker and watchdog
  always @(posedge clk_i) begin
    com_result_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_q.size() == 0) begin
          $display("MISMATCH unexpected result at %0t", $realtime);
          errors++;
        end else begin
          w = pending_q.pop_front();
          if (com_x_pos_o !== w.px) report("com_x_pos", com_x_pos_o, w.px);
          if (com_y_pos_o !== w.py) report("com_y_pos", com_y_pos_o, w.py);
          if (com_x_vel_o !== w.vx) report("com_x_vel", com_x_vel_o, w.vx);
          if (com_y_vel_o !== w.vy) report("com_y_vel", com_y_vel_o, w.vy);
          if (zmp_x_est_o !== w.zx) report("zmp_x_est", zmp_x_est_o, w.zx);
          if (zmp_y_est_o !== w.zy) report("zmp_y_est", zmp_y_est_o, w.zy);
        end
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  stim_row_t dir_rows [$];

  initial begin
    stim_row_t r;
    cfg_we_i = 1'b0; cfg_idx_i = REG_STEP_DT; cfg_data_i = '0;
    in_valid_i = 1'b0; opcode_i = OPC_GAIN; gain_index_i = '0; gain_value_i = '0;
    ref_x_i = '0; ref_y_i = '0;
    errors = 0; items_sent = 0; results_seen = 0; gain_loads = 0; idle_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    k_dt = 128'sd10995116278; k_h = 128'sd54975581; k_s6 = 128'sd183251;
    k_ratio = '0; k_fp = '0; k_fv = '0; k_fa = '0;
    for (int a = 0; a < 2; a++)
      for (int k = 0; k < 3; k++) cart_st[a][k] = '0;
    win_head = 0; win_fill = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // define every gain, then fill all but one window entry with zero samples
    for (int i = 0; i < NSTEPS; i++)
      send_item(mk_row(OPC_GAIN, 7'(i), '0, $urandom, $urandom));
    for (int i = 0; i < NSTEPS - 1; i++)
      send_item(mk_row(OPC_SAMPLE, 7'($urandom), rand40(), '0, '0));

    // directed rows
    r = mk_row(OPC_SAMPLE, 7'h7f, 40'h7f_ffff_ffff, '0, '0);
    r.typed = 1'b1;                      // zero state, zero gains: all zero
    dir_rows.push_back(r);
    dir_rows.push_back(mk_row(OPC_GAIN, 7'd0, 40'h7f_ffff_ffff, 32'h7fff_ffff, 32'h8000_0000));
    dir_rows.push_back(mk_row(OPC_GAIN, 7'd127, 40'h80_0000_0000, '0, '1));
    dir_rows.push_back(mk_row(OPC_GAIN, 7'd64, 40'h1_0000, '0, '0));
    dir_rows.push_back(mk_row(OPC_SAMPLE, 7'd0, '0, 32'h7fff_ffff, 32'h7fff_ffff));
    dir_rows.push_back(mk_row(OPC_SAMPLE, 7'h55, 40'haa_aaaa_aaaa,
                              32'h8000_0000, 32'h8000_0000));
    dir_rows.push_back(mk_row(OPC_SAMPLE, 7'h2a, 40'h55_5555_5555, 32'h0001_0000, 32'hffff_0000));
    dir_rows.push_back(mk_row(OPC_GAIN, 7'd0, 40'h1_0000, '0, '0));
    dir_rows.push_back(mk_row(OPC_GAIN, 7'd127, 40'hff_ffff_0000, '0, '0));
    dir_rows.push_back(mk_row(OPC_SAMPLE, '0, '0, 32'h0000_8000, 32'hffff_8000));
    dir_rows.push_back(mk_row(OPC_SAMPLE, '0, '0, 32'h7fff_ffff, 32'h8000_0000));
    dir_rows.push_back(mk_row(OPC_SAMPLE, '1, '1, '0, '0));
    dir_rows.push_back(mk_row(OPC_SAMPLE, '0, '0, '1, '1));
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    // random phases, each with its own register setting and idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_STEP_DT, 40'd10995116278);
          write_reg(REG_HALF_DT2, 40'd54975581);
          write_reg(REG_SIXTH_DT3, 40'd183251);
          write_reg(REG_ZMP_RATIO, 40'd24000000000);
          write_reg(REG_FB_POS, 40'h0_0010_0000);
          write_reg(REG_FB_VEL, 40'h0_0002_0000);
          write_reg(REG_FB_ACC, 40'hff_fffe_0000);
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          write_reg(REG_STEP_DT, '1);
          write_reg(REG_HALF_DT2, '1);
          write_reg(REG_SIXTH_DT3, '1);
          write_reg(REG_ZMP_RATIO, '1);
          write_reg(REG_FB_POS, 40'h7f_ffff_ffff);
          write_reg(REG_FB_VEL, 40'h7f_ffff_ffff);
          write_reg(REG_FB_ACC, 40'h7f_ffff_ffff);
          send_idle_pct = 59; recv_stall_pct = 0;
        end
        2: begin
          write_reg(REG_STEP_DT, '0);
          write_reg(REG_HALF_DT2, '0);
          write_reg(REG_SIXTH_DT3, '0);
          write_reg(REG_ZMP_RATIO, '0);
          write_reg(REG_FB_POS, 40'h80_0000_0000);
          write_reg(REG_FB_VEL, 40'h80_0000_0000);
          write_reg(REG_FB_ACC, 40'h80_0000_0000);
          send_idle_pct = 0;  recv_stall_pct = 59;
        end
        default: begin
          write_reg(REG_STEP_DT, rand40());
          write_reg(REG_HALF_DT2, {8'h0, $urandom});
          write_reg(REG_SIXTH_DT3, {16'h0, 24'($urandom)});
          write_reg(REG_ZMP_RATIO, rand40());
          write_reg(REG_FB_POS, rand40());
          write_reg(REG_FB_VEL, $signed(40'($urandom_range(1 << 22))) - (1 << 21));
          write_reg(REG_FB_ACC, rand40());
          send_idle_pct = 22; recv_stall_pct = 22;
        end
      endcase
      for (int n = 0; n < 290; n++) send_item(rand_row());
    end
    end_burst();

    // wait for outstanding results, then a quiet tail
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d transactions (%0d gain loads), %0d control steps checked",
             items_sent, gain_loads, results_seen);
    $display("register settings: nominal, all-max, all-zero/min, random");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
